// File: hdl/rpo_pkg.sv
// Shared types and constants for the rounded panel overlay shader.
// No dependencies; rpo_cfg, rpo_geom, rpo_shade and the top level refer to it by scoped name.
package rpo_pkg;

  // Register file layout
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    RegLeft   = 3'd0,
    RegTop    = 3'd1,
    RegWidth  = 3'd2,
    RegHeight = 3'd3,
    RegRadius = 3'd4
  } reg_idx_e;

  localparam logic [9:0]  LEFT_RST   = 10'd180;
  localparam logic [9:0]  TOP_RST    = 10'd125;
  localparam logic [9:0]  WIDTH_RST  = 10'd280;
  localparam logic [9:0]  HEIGHT_RST = 10'd220;
  localparam logic [7:0]  RADIUS_RST = 8'd18;
  localparam logic [15:0] RSQ_RST    = 16'd324;

  // Panel decoration
  localparam int SHADOW_OFFSET = 4;
  localparam int OUTER_DEPTH   = 2;
  localparam int INNER_DEPTH   = 4;
  localparam int BAND_FIRST    = 3;
  localparam int BAND_END      = 30;

  localparam logic [15:0] COLOR_WHITE  = 16'hFFFF;
  localparam logic [15:0] COLOR_INNER  = 16'hEF7D;
  localparam logic [15:0] COLOR_BODY   = 16'hEF5D;
  localparam logic [15:0] COLOR_SHADOW = 16'h0000;

  typedef struct packed {
    logic [9:0] panel_left;
    logic [9:0] panel_top;
    logic [9:0] panel_width;
    logic [9:0] panel_height;
    logic [7:0] corner_radius;
  } cfg_t;

  // Per-point geometry, everything short of the corner distance test
  typedef struct packed {
    logic       in_rect;  // within the bounding rectangle
    logic       mid;      // in the cross, clear of all corner zones
    logic [7:0] adx;      // |dx| to the corner centre
    logic [7:0] ady;      // |dy| to the corner centre
    logic       outer;
    logic       inner;
    logic       band;
  } geom_t;

  typedef struct packed {
    geom_t pan;
    geom_t shd;
    logic  even;
    logic  diag;
  } stage_t;

endpackage

// File: hdl/rpo_pix_if.sv
// Pixel coordinate channel: valid/ready handshake plus the coordinate pair.
// Depends on nothing.
interface rpo_pix_if #(
  parameter int COORD_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: hdl/rpo_res_if.sv
// Shading result channel: valid/ready handshake plus write enable and colour.
// Depends on nothing.
interface rpo_res_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [15:0] pixel_color;

  modport source (output valid, output write_enable, output pixel_color, input ready);
  modport sink   (input valid, input write_enable, input pixel_color, output ready);
endinterface

// File: hdl/rpo_cfg.sv
// APB register file for the panel geometry, with a registered radius square.
// Depends on rpo_pkg.
module rpo_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [rpo_pkg::CFG_ADDR_W-1:0]  paddr_i,
  input  logic [rpo_pkg::CFG_DATA_W-1:0]  pwdata_i,
  output logic [rpo_pkg::CFG_DATA_W-1:0]  prdata_o,
  output rpo_pkg::cfg_t                   cfg_o,
  output logic [15:0]                     rsq_o
);

  rpo_pkg::cfg_t     cfg_q, cfg_d;
  logic [15:0]       rsq_q, rsq_d;
  logic              wr_en;
  rpo_pkg::reg_idx_e idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = rpo_pkg::reg_idx_e'(paddr_i[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    rsq_d = rsq_q;
    if (wr_en) begin
      unique case (idx)
        rpo_pkg::RegLeft:   cfg_d.panel_left   = pwdata_i[9:0];
        rpo_pkg::RegTop:    cfg_d.panel_top    = pwdata_i[9:0];
        rpo_pkg::RegWidth:  cfg_d.panel_width  = pwdata_i[9:0];
        rpo_pkg::RegHeight: cfg_d.panel_height = pwdata_i[9:0];
        rpo_pkg::RegRadius: begin
          cfg_d.corner_radius = pwdata_i[7:0];
          rsq_d = 16'(pwdata_i[7:0]) * 16'(pwdata_i[7:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.panel_left    <= rpo_pkg::LEFT_RST;
      cfg_q.panel_top     <= rpo_pkg::TOP_RST;
      cfg_q.panel_width   <= rpo_pkg::WIDTH_RST;
      cfg_q.panel_height  <= rpo_pkg::HEIGHT_RST;
      cfg_q.corner_radius <= rpo_pkg::RADIUS_RST;
      rsq_q               <= rpo_pkg::RSQ_RST;
    end else begin
      cfg_q <= cfg_d;
      rsq_q <= rsq_d;
    end
  end

  always_comb begin
    unique case (idx)
      rpo_pkg::RegLeft:   prdata_o = rpo_pkg::CFG_DATA_W'(cfg_q.panel_left);
      rpo_pkg::RegTop:    prdata_o = rpo_pkg::CFG_DATA_W'(cfg_q.panel_top);
      rpo_pkg::RegWidth:  prdata_o = rpo_pkg::CFG_DATA_W'(cfg_q.panel_width);
      rpo_pkg::RegHeight: prdata_o = rpo_pkg::CFG_DATA_W'(cfg_q.panel_height);
      rpo_pkg::RegRadius: prdata_o = rpo_pkg::CFG_DATA_W'(cfg_q.corner_radius);
      default:            prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;
  assign rsq_o = rsq_q;

endmodule

// File: hdl/rpo_geom.sv
// Edge compares and corner offsets of one point against the rounded panel,
// optionally moved by a fixed offset. Depends on rpo_pkg.
module rpo_geom #(
  parameter int COORD_BITS = 11,
  parameter int OFFSET     = 0
) (
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  rpo_pkg::cfg_t         cfg_i,
  output rpo_pkg::geom_t        geom_o
);

  // Two spare bits: sign, and headroom for left+width past 11 bits
  localparam int WW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;

  localparam logic signed [WW-1:0] ONE  = WW'(1);
  localparam logic signed [WW-1:0] OFS  = WW'(OFFSET);
  localparam logic signed [WW-1:0] DOUT = WW'(rpo_pkg::OUTER_DEPTH);
  localparam logic signed [WW-1:0] DIN  = WW'(rpo_pkg::INNER_DEPTH);
  localparam logic signed [WW-1:0] BFST = WW'(rpo_pkg::BAND_FIRST);
  localparam logic signed [WW-1:0] BEND = WW'(rpo_pkg::BAND_END);

  logic signed [WW-1:0] px, py, lx, ty, xe, ye, rr;
  logic signed [WW-1:0] lr, tr, xr, yr, cx, cy, dx, dy, ndx, ndy;

  assign px = $signed({{(WW-COORD_BITS){1'b0}}, pixel_x_i}) - OFS;
  assign py = $signed({{(WW-COORD_BITS){1'b0}}, pixel_y_i}) - OFS;
  assign lx = $signed(WW'(cfg_i.panel_left));
  assign ty = $signed(WW'(cfg_i.panel_top));
  assign rr = $signed(WW'(cfg_i.corner_radius));
  assign xe = lx + $signed(WW'(cfg_i.panel_width));
  assign ye = ty + $signed(WW'(cfg_i.panel_height));

  assign lr = lx + rr;
  assign tr = ty + rr;
  assign xr = xe - rr;
  assign yr = ye - rr;

  // Corner centre sits radius-1 in from left/top, radius in from right/bottom
  assign cx  = (px < lr) ? (lr - ONE) : xr;
  assign cy  = (py < tr) ? (tr - ONE) : yr;
  assign dx  = px - cx;
  assign dy  = py - cy;
  assign ndx = -dx;
  assign ndy = -dy;

  // Offsets only matter inside the rectangle, where |d| stays below radius
  assign geom_o.adx = dx[WW-1] ? ndx[7:0] : dx[7:0];
  assign geom_o.ady = dy[WW-1] ? ndy[7:0] : dy[7:0];

  assign geom_o.in_rect = (px >= lx) && (py >= ty) && (px < xe) && (py < ye);
  assign geom_o.mid     = ((px >= lr) && (px < xr)) || ((py >= tr) && (py < yr));

  assign geom_o.outer = (px < lx + DOUT) || (px >= xe - DOUT) ||
                        (py < ty + DOUT) || (py >= ye - DOUT);
  assign geom_o.inner = (px < lx + DIN) || (px >= xe - DIN) ||
                        (py < ty + DIN) || (py >= ye - DIN);
  assign geom_o.band  = (py >= ty + BFST) && (py < ty + BEND);

endmodule

// File: hdl/rpo_shade.sv
// Corner distance tests and colour selection for panel over shadow.
// Depends on rpo_pkg.
module rpo_shade (
  input  rpo_pkg::stage_t stage_i,
  input  logic [15:0]     rsq_i,
  output logic            write_enable_o,
  output logic [15:0]     pixel_color_o
);

  logic [15:0] pan_xx, pan_yy, shd_xx, shd_yy;
  logic [16:0] pan_d2, shd_d2;
  logic        pan_in, shd_in;

  assign pan_xx = 16'(stage_i.pan.adx) * 16'(stage_i.pan.adx);
  assign pan_yy = 16'(stage_i.pan.ady) * 16'(stage_i.pan.ady);
  assign shd_xx = 16'(stage_i.shd.adx) * 16'(stage_i.shd.adx);
  assign shd_yy = 16'(stage_i.shd.ady) * 16'(stage_i.shd.ady);
  assign pan_d2 = 17'(pan_xx) + 17'(pan_yy);
  assign shd_d2 = 17'(shd_xx) + 17'(shd_yy);

  assign pan_in = stage_i.pan.in_rect && (stage_i.pan.mid || (pan_d2 <= 17'(rsq_i)));
  assign shd_in = stage_i.shd.in_rect && (stage_i.shd.mid || (shd_d2 <= 17'(rsq_i)));

  always_comb begin
    write_enable_o = 1'b0;
    pixel_color_o  = '0;
    if (pan_in) begin
      if (stage_i.pan.outer) begin
        write_enable_o = 1'b1;
        pixel_color_o  = rpo_pkg::COLOR_WHITE;
      end else if (stage_i.even) begin
        write_enable_o = 1'b1;
        if (stage_i.pan.inner) begin
          pixel_color_o = rpo_pkg::COLOR_INNER;
        end else if (stage_i.pan.band) begin
          pixel_color_o = rpo_pkg::COLOR_WHITE;
        end else begin
          pixel_color_o = rpo_pkg::COLOR_BODY;
        end
      end
    end
    // Shadow shows through wherever the panel left the pixel alone
    if (!write_enable_o && stage_i.diag && shd_in) begin
      write_enable_o = 1'b1;
      pixel_color_o  = rpo_pkg::COLOR_SHADOW;
    end
  end

endmodule

// File: hdl/rounded_panel_overlay_shader.sv
// Top level of the rounded panel overlay shader: APB registers, two-stage
// pixel pipeline. Depends on rpo_pkg, rpo_pix_if, rpo_res_if, rpo_cfg,
// rpo_geom and rpo_shade.
//
//   channel  dir  handshake       beat contents
//   pix_in   in   valid/ready     pixel_x, pixel_y
//   res_out  out  valid/ready     write_enable, pixel_color
//   apb      in   psel/penable    5 registers at byte address 4*i
//
// One pixel per clock while res_out is not stalled.
// Stage one holds edge compares and corner offsets, stage two the corner
// squares and colour, which is the output register.
// ready drops only when both stages hold a beat and res_out is stalled.
// Reset empties the pipeline and loads the default panel geometry.
module rounded_panel_overlay_shader #(
  parameter int COORD_BITS = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpo_pix_if.sink                        pix_in,
  rpo_res_if.source                      res_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpo_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpo_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rpo_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  rpo_pkg::cfg_t   cfg;
  logic [15:0]     rsq;
  rpo_pkg::stage_t stage_d, stage_q;
  logic            s1_vld_q, s2_vld_q;
  logic            adv1, adv2;
  logic            we_d, we_q;
  logic [15:0]     color_d, color_q;

  assign pready = 1'b1;

  rpo_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg),
    .rsq_o     (rsq)
  );

  rpo_geom #(
    .COORD_BITS (COORD_BITS),
    .OFFSET     (0)
  ) u_geom_pan (
    .pixel_x_i (pix_in.pixel_x),
    .pixel_y_i (pix_in.pixel_y),
    .cfg_i     (cfg),
    .geom_o    (stage_d.pan)
  );

  rpo_geom #(
    .COORD_BITS (COORD_BITS),
    .OFFSET     (rpo_pkg::SHADOW_OFFSET)
  ) u_geom_shd (
    .pixel_x_i (pix_in.pixel_x),
    .pixel_y_i (pix_in.pixel_y),
    .cfg_i     (cfg),
    .geom_o    (stage_d.shd)
  );

  // Checkerboard parity and every fourth diagonal; the shadow offset is
  // a multiple of four so both tests hold for either point
  assign stage_d.even = ~(pix_in.pixel_x[0] ^ pix_in.pixel_y[0]);
  assign stage_d.diag = (2'(pix_in.pixel_x[1:0] + pix_in.pixel_y[1:0]) == 2'b00);

  rpo_shade u_shade (
    .stage_i        (stage_q),
    .rsq_i          (rsq),
    .write_enable_o (we_d),
    .pixel_color_o  (color_d)
  );

  assign adv2 = ~s2_vld_q | res_out.ready;
  assign adv1 = ~s1_vld_q | adv2;

  assign pix_in.ready         = adv1;
  assign res_out.valid        = s2_vld_q;
  assign res_out.write_enable = we_q;
  assign res_out.pixel_color  = color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_vld_q <= pix_in.valid;
      end
      if (adv2) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      stage_q <= stage_d;
    end
    if (adv2) begin
      we_q    <= we_d;
      color_q <= color_d;
    end
  end

endmodule

// File: bench/rpo_shade_checker.sv
// Watches the pixel, result and register ports of the overlay shader,
// predicts each result and compares it. Depends on rpo_pkg, rpo_pix_if and rpo_res_if.
module rpo_shade_checker #(
  parameter int COORD_BITS = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpo_pix_if                             pix,
  rpo_res_if                             res,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [rpo_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [rpo_pkg::CFG_DATA_W-1:0] pwdata_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import rpo_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  write_enable;
    logic [15:0]           pixel_color;
  } shade_t;

  cfg_t   panel;
  shade_t pending_shades[$];

  // Rounded-rectangle membership; corner centres sit r-1 in from left/top
  // and r in from right/bottom
  function automatic bit in_rounded(cfg_t c, int px, int py);
    int x, y, w, h, r, cx, cy, dx, dy;
    x = c.panel_left;
    y = c.panel_top;
    w = c.panel_width;
    h = c.panel_height;
    r = c.corner_radius;
    if (px < x || py < y || px >= x + w || py >= y + h) return 1'b0;
    if (px >= x + r && px < x + w - r) return 1'b1;
    if (py >= y + r && py < y + h - r) return 1'b1;
    cx = (px < x + r) ? x + r - 1 : x + w - r;
    cy = (py < y + r) ? y + r - 1 : y + h - r;
    dx = px - cx;
    dy = py - cy;
    return (dx * dx + dy * dy) <= r * r;
  endfunction

  function automatic shade_t shade_pixel(cfg_t c, logic [COORD_BITS-1:0] xi,
                                         logic [COORD_BITS-1:0] yi);
    shade_t s;
    int     px, py, x, y, w, h;
    bit     even, outer, inner, band;
    px = xi;
    py = yi;
    x  = c.panel_left;
    y  = c.panel_top;
    w  = c.panel_width;
    h  = c.panel_height;
    s.x = xi;
    s.y = yi;
    s.write_enable = 1'b0;
    s.pixel_color  = 16'h0;
    even = ((px ^ py) & 1) == 0;
    if (in_rounded(c, px, py)) begin
      outer = px < x + OUTER_DEPTH || px >= x + w - OUTER_DEPTH ||
              py < y + OUTER_DEPTH || py >= y + h - OUTER_DEPTH;
      inner = px < x + INNER_DEPTH || px >= x + w - INNER_DEPTH ||
              py < y + INNER_DEPTH || py >= y + h - INNER_DEPTH;
      band  = py >= y + BAND_FIRST && py < y + BAND_END;
      if (outer) begin
        s.write_enable = 1'b1;
        s.pixel_color  = COLOR_WHITE;
      end else if (even) begin
        s.write_enable = 1'b1;
        s.pixel_color  = inner ? COLOR_INNER : (band ? COLOR_WHITE : COLOR_BODY);
      end
    end
    // shadow only shows through where the panel left the pixel alone
    if (!s.write_enable && ((px + py) & 3) == 0 &&
        in_rounded(c, px - SHADOW_OFFSET, py - SHADOW_OFFSET)) begin
      s.write_enable = 1'b1;
      s.pixel_color  = COLOR_SHADOW;
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shade_t want;
    if (!rst_ni) begin
      panel = '{LEFT_RST, TOP_RST, WIDTH_RST, HEIGHT_RST, RADIUS_RST};
      pending_shades.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          RegLeft:   panel.panel_left    = pwdata_i[9:0];
          RegTop:    panel.panel_top     = pwdata_i[9:0];
          RegWidth:  panel.panel_width   = pwdata_i[9:0];
          RegHeight: panel.panel_height  = pwdata_i[9:0];
          RegRadius: panel.corner_radius = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (pending_shades.size() == 0) begin
          $display("%0t: result beat we=%0b color=%h with nothing expected",
                   $time, res.write_enable, res.pixel_color);
          fail_count_o++;
        end else begin
          want = pending_shades.pop_front();
          checked_o++;
          if (res.write_enable !== want.write_enable) begin
            $display("%0t: (%0d,%0d) write_enable expected %0b actual %0b", $time,
                     want.x, want.y, want.write_enable, res.write_enable);
            fail_count_o++;
          end
          if (res.pixel_color !== want.pixel_color) begin
            $display("%0t: (%0d,%0d) pixel_color expected %h actual %h", $time,
                     want.x, want.y, want.pixel_color, res.pixel_color);
            fail_count_o++;
          end
        end
      end
      if (pix.valid && pix.ready)
        pending_shades.push_back(shade_pixel(panel, pix.pixel_x, pix.pixel_y));
      pending_o = pending_shades.size();
    end
  end

endmodule

// File: bench/tb_rounded_panel_overlay_shader.sv
// Stimulus and verdict for the rounded panel overlay shader: panel settings
// over APB, pixel beats with random gaps and stalls. Depends on rpo_pkg, the
// channel interfaces, rpo_shade_checker and the block itself.
module tb_rounded_panel_overlay_shader;
  import rpo_pkg::*;

  localparam int COORD_BITS  = 11;
  localparam int SPARE_REG   = 5;    // first index past the register list
  localparam int GAP_PCT     = 37;
  localparam int HOLD_CYCLES = 150;
  localparam int N_PANELS    = 10;
  localparam int BURST_BEATS = 172;
  localparam int N_DIRECTED  = 22;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int checked;
  int beats_sent  = 0;
  int src_gap_pct = GAP_PCT;
  int snk_gap_pct = GAP_PCT;
  bit long_hold   = 1'b0;
  int cur_left    = LEFT_RST;
  int cur_top     = TOP_RST;
  int cur_width   = WIDTH_RST;
  int cur_height  = HEIGHT_RST;

  // Hand-picked points against the reset panel: range corners, each border
  // ring, band edges, body, checkerboard gaps and the shadow past the edges
  logic [COORD_BITS-1:0] dir_x [N_DIRECTED] = '{
    0, 2047, 0, 2047, 1365, 180, 186, 200, 200, 200, 201,
    300, 301, 300, 301, 462, 463, 464, 459, 460, 456, 300};
  logic [COORD_BITS-1:0] dir_y [N_DIRECTED] = '{
    0, 2047, 2047, 0, 682, 125, 130, 125, 126, 127, 127,
    150, 150, 200, 155, 198, 197, 200, 300, 300, 300, 154};

  rpo_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
  rpo_res_if                            res_ch ();

  always #2 clk_i = ~clk_i;

  rounded_panel_overlay_shader #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_ch),
    .res_out (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rpo_shade_checker #(.COORD_BITS(COORD_BITS)) shade_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pix_ch),
    .res          (res_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  task automatic cfg_write(input int unsigned idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper bits carry junk so the register masking gets exercised too
  task automatic set_panel(input int l, input int t, input int w, input int h,
                           input int r);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(RegLeft,   {junk[31:10], l[9:0]});
    cfg_write(RegTop,    {junk[31:10], t[9:0]});
    cfg_write(RegWidth,  {junk[31:10], w[9:0]});
    cfg_write(RegHeight, {junk[31:10], h[9:0]});
    cfg_write(RegRadius, {junk[31:8],  r[7:0]});
    cfg_write(SPARE_REG + $urandom_range(2), $urandom);
    cur_left   = l;
    cur_top    = t;
    cur_width  = w;
    cur_height = h;
  endtask

  task automatic send_pixel(input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    @(negedge clk_i);
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    do @(posedge clk_i); while (!pix_ch.ready);
    beats_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    pix_ch.valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Mostly near the panel and its shadow, clamped to the coordinate range
  function automatic logic [COORD_BITS-1:0] aim(input int lo, input int span);
    int v;
    v = lo - 8 + int'($urandom_range(span + 16));
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[COORD_BITS-1:0];
  endfunction

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold = 1'b0;
      end
      res_ch.ready <= ($urandom_range(99) >= snk_gap_pct);
    end
  end

  initial begin
    pix_ch.valid   = 1'b0;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_ni         = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < N_PANELS; p++) begin
      src_gap_pct = GAP_PCT;
      snk_gap_pct = GAP_PCT;
      case (p)
        0: for (int i = 0; i < N_DIRECTED; i++) send_pixel(dir_x[i], dir_y[i]);
        1: begin
          set_panel(0, 0, 1023, 1023, 0);
          long_hold = 1'b1;  // sink holds off, pipeline backs up into pix_in
        end
        2: begin
          set_panel(1023, 1023, 1023, 1023, 255);
          src_gap_pct = 0;
          snk_gap_pct = 0;
        end
        3: set_panel(100, 50, 40, 30, 200);  // corner zones overlap
        4: set_panel(300, 300, 0, 50, 10);
        5: set_panel(20, 700, 90, 0, 5);
        6: set_panel(0, 0, 1, 1, 1);
        7: set_panel($urandom_range(1023), $urandom_range(1023),
                     $urandom_range(400, 1), $urandom_range(400, 1), $urandom_range(40));
        default: set_panel($urandom_range(1023), $urandom_range(1023),
                           $urandom_range(1023, 1), $urandom_range(1023, 1),
                           $urandom_range(255));
      endcase
      for (int i = 0; i < BURST_BEATS; i++) begin
        if ($urandom_range(3) == 0)
          send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
        else
          send_pixel(aim(cur_left, cur_width), aim(cur_top, cur_height));
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Sent %0d pixel beats over %0d panel settings; %0d results compared,",
             beats_sent, N_PANELS, checked);
    $display("including a %0d-cycle result stall and a gap-free stretch.", HOLD_CYCLES);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

endmodule
